>>> sv/ddw_pkg.sv
// Shared types, widths and calendar helpers for the date difference block.
package ddw_pkg;

  localparam int DAY_W    = 5;
  localparam int MON_W    = 4;
  localparam int YEAR_W   = 14;
  localparam int DCNT_W   = 22;
  localparam int WK_W     = 3;
  // Day numbers of any date with a 14-bit year fit in 23 bits.
  localparam int ORD_W    = 23;
  // Wide enough for both a 14-bit year and the largest year limit.
  localparam int YCMP_W   = 17;

  localparam int MAX_YEAR_DEF  = 9999;
  localparam int MONTHS_IN_YR  = 12;
  localparam int DAYS_IN_YR    = 365;
  localparam int CENTURY_LAST  = 99;
  localparam int QUAD_CENT_LAST = 399;

  typedef struct packed {
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
    logic [DAY_W-1:0]  end_day;
    logic [MON_W-1:0]  end_month;
    logic [YEAR_W-1:0] end_year;
  } req_t;

  typedef struct packed {
    logic              both_valid;
    logic [DCNT_W-1:0] day_count;
    logic [WK_W-1:0]   start_weekday;
    logic [WK_W-1:0]   end_weekday;
  } rsp_t;

  // Length of a month; zero for a code that is no month.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                              len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:           len = DAY_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                      len = DAY_W'(31);
      default:                           len = '0;
    endcase
    return len;
  endfunction

  // (w + x) mod 7 for a residue w and a value x below 32.
  function automatic logic [WK_W-1:0] add_mod7(input logic [WK_W-1:0] w,
                                               input logic [DAY_W-1:0] x);
    logic [5:0] s;
    s = 6'(w) + 6'(x);
    if (s >= 6'd28) s = s - 6'd28;
    if (s >= 6'd14) s = s - 6'd14;
    if (s >= 6'd7)  s = s - 6'd7;
    return s[WK_W-1:0];
  endfunction

endpackage

>>> sv/date_difference_and_weekday.sv
// Gregorian date check, day difference and weekday block built on one shared adder.
//
// A request carries a start and an end date. Both are checked (year 1 to MAX_YEAR,
// month 1 to 12, day within the month with the leap rule for February). For valid
// dates the response gives the days from start to end (0 if the start is not
// earlier) and each weekday, 0 Saturday through 6 Friday. A sequencer walks a year
// counter from year 1 up to the later of the two years, adding each year's length
// in one shared adder, then walks the months of each date and subtracts the two day
// numbers in the same adder. A bad year or month goes straight to the response step
// after acceptance, and a bad day is found when the year walk ends, before the months.
// The block is ready again once its response is registered. The block takes no new
// request until it has handed its result to the output register, which then waits
// independently for the consumer; while that register is still full the last step
// waits as well.
module date_difference_and_weekday #(
  parameter int MAX_YEAR = ddw_pkg::MAX_YEAR_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ddw_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ddw_pkg::rsp_t  rsp
);
  import ddw_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_YEARS, S_LOAD, S_MONTHS, S_EMIT} state_t;

  state_t            state;
  req_t              req_q;
  logic [YEAR_W-1:0] yc, ymax;
  logic [1:0]        c4;
  logic [6:0]        c100;
  logic [8:0]        c400;
  logic [ORD_W-1:0]  acc, base_s, base_e, ord_s, ord_e;
  logic [WK_W-1:0]   w7, wb_s, wb_e, wk_s, wk_e;
  logic              leap_s, leap_e, sel, ok;
  logic [MON_W-1:0]  mc;

  logic              leap_now, pre_ok, day_ok_s, day_ok_e, month_step;
  logic [DAY_W-1:0]  cur_day, cur_len;
  logic [MON_W-1:0]  cur_month;
  logic              cur_leap;
  logic [ORD_W-1:0]  add_a, add_b, sum;
  logic              add_cin;

  function automatic logic ym_ok(input logic [YEAR_W-1:0] y, input logic [MON_W-1:0] m);
    return (y != '0) && (YCMP_W'(y) <= YCMP_W'(MAX_YEAR)) &&
           (m != '0) && (m <= MON_W'(MONTHS_IN_YR));
  endfunction

  assign pre_ok   = ym_ok(req.start_year, req.start_month) &&
                    ym_ok(req.end_year, req.end_month);
  assign leap_now = (c4 == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
  assign day_ok_s = (req_q.start_day != '0) &&
                    (req_q.start_day <= month_days(req_q.start_month, leap_s));
  assign day_ok_e = (req_q.end_day != '0) &&
                    (req_q.end_day <= month_days(req_q.end_month, leap_e));

  assign cur_day    = sel ? req_q.end_day   : req_q.start_day;
  assign cur_month  = sel ? req_q.end_month : req_q.start_month;
  assign cur_leap   = sel ? leap_e          : leap_s;
  assign cur_len    = month_days(mc, cur_leap);
  assign month_step = (mc < cur_month);

  // The one adder: year lengths, month lengths, the day, and the final difference.
  always_comb begin
    add_a   = acc;
    add_b   = '0;
    add_cin = 1'b0;
    case (state)
      S_YEARS:  add_b = ORD_W'(DAYS_IN_YR) + ORD_W'(leap_now);
      S_MONTHS: add_b = month_step ? ORD_W'(cur_len) : ORD_W'(cur_day);
      S_EMIT: begin
        add_a   = ord_e;
        add_b   = ~ord_s;
        add_cin = 1'b1;
      end
      default: add_b = '0;
    endcase
  end
  assign sum = add_a + add_b + ORD_W'(add_cin);

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      w7        <= '0;
      c100      <= '0;
      c400      <= '0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_EMIT)) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            ymax  <= (req.start_year > req.end_year) ? req.start_year : req.end_year;
            yc    <= YEAR_W'(1);
            acc   <= '0;
            // Day one of year one is a Monday, code 2, so (days before + 1) mod 7.
            w7    <= WK_W'(1);
            c4    <= 2'd1;
            c100  <= 7'd1;
            c400  <= 9'd1;
            sel   <= 1'b0;
            ok    <= pre_ok;
            state <= pre_ok ? S_YEARS : S_EMIT;
          end
        end
        S_YEARS: begin
          if (yc == req_q.start_year) begin
            base_s <= acc;
            wb_s   <= w7;
            leap_s <= leap_now;
          end
          if (yc == req_q.end_year) begin
            base_e <= acc;
            wb_e   <= w7;
            leap_e <= leap_now;
          end
          acc  <= sum;
          w7   <= add_mod7(w7, leap_now ? DAY_W'(2) : DAY_W'(1));
          c4   <= c4 + 2'd1;
          c100 <= (c100 == 7'(CENTURY_LAST)) ? 7'd0 : c100 + 7'd1;
          c400 <= (c400 == 9'(QUAD_CENT_LAST)) ? 9'd0 : c400 + 9'd1;
          if (yc == ymax) state <= S_LOAD;
          else yc <= yc + YEAR_W'(1);
        end
        S_LOAD: begin
          acc <= sel ? base_e : base_s;
          w7  <= sel ? wb_e : wb_s;
          mc  <= MON_W'(1);
          if (!sel && !(day_ok_s && day_ok_e)) begin
            ok    <= 1'b0;
            state <= S_EMIT;
          end else begin
            state <= S_MONTHS;
          end
        end
        S_MONTHS: begin
          if (month_step) begin
            acc <= sum;
            w7  <= add_mod7(w7, cur_len);
            mc  <= mc + MON_W'(1);
          end else if (!sel) begin
            ord_s <= sum;
            wk_s  <= add_mod7(w7, cur_day);
            sel   <= 1'b1;
            state <= S_LOAD;
          end else begin
            ord_e <= sum;
            wk_e  <= add_mod7(w7, cur_day);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.both_valid    <= ok;
            rsp.day_count     <= (ok && (ord_e > ord_s)) ? sum[DCNT_W-1:0] : '0;
            rsp.start_weekday <= ok ? wk_s : '0;
            rsp.end_weekday   <= ok ? wk_e : '0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The mod 4 year residue must follow the year counter during the walk.
  a_quad_tracks_year: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEARS) |-> (c4 == yc[1:0]))
    else $error("year mod 4 counter out of step");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEARS) |-> (yc <= ymax))
    else $error("year walk passed the later year");

  a_residues_in_range: assert property (@(posedge clk) disable iff (rst)
    (c100 <= 7'(CENTURY_LAST)) && (c400 <= 9'(QUAD_CENT_LAST)) && (w7 < WK_W'(7)))
    else $error("residue counter out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.both_valid) |->
      (rsp.day_count == '0) && (rsp.start_weekday == '0) && (rsp.end_weekday == '0))
    else $error("invalid result carries nonzero fields");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

endmodule

>>> tb/sv/date_difference_and_weekday_tb.sv
// Self-checking testbench for the Gregorian day difference and weekday block.
module date_difference_and_weekday_tb;
  import ddw_pkg::*;

  localparam int unsigned YEAR_LIMIT  = MAX_YEAR_DEF;
  localparam int          RANDOM_REQS = 70;
  localparam int          FILL_REQS   = 6;
  localparam int          PARK_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 20;
  // A top-year request walks every year up to the limit before it answers; allow for that.
  localparam int          STALL_LIMIT = 60000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TICK} rx_mode_t;
  typedef enum int {
    BAD_DAY_ZERO, BAD_DAY_HIGH, BAD_MONTH_ZERO, BAD_MONTH_HIGH, BAD_YEAR_ZERO, BAD_YEAR_HIGH
  } fault_t;

  typedef struct packed {
    req_t stim;
    logic typed;
    rsp_t want;
  } plan_row_t;

  localparam rsp_t REJECTED = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  rsp_t        pending_spans[$];
  plan_row_t   plan[$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          responses_seen = 0;
  int          dated_responses = 0;
  int unsigned widest_span = 0;
  int          burst_left = 0;
  bit          park_receiver = 1'b0;

  date_difference_and_weekday dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Calendar arithmetic used to forecast each response.
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic bit date_is_real(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
    if (y < 1 || y > YEAR_LIMIT || m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= month_length(m, is_leap_year(y));
  endfunction

  // Day 1 is the first of January of year 1.
  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned i = 1; i < m; i++) n += month_length(i, is_leap_year(y));
    return n + d;
  endfunction

  // Zeller's congruence: January and February count as months 13 and 14 of the prior year.
  function automatic logic [WK_W-1:0] weekday_of(input int unsigned d, input int unsigned m,
                                                 input int unsigned y);
    int unsigned mm;
    int unsigned yy;
    int unsigned k;
    int unsigned j;
    mm = m;
    yy = y;
    if (mm < 3) begin
      mm += 12;
      yy -= 1;
    end
    k = yy % 100;
    j = yy / 100;
    return WK_W'((d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
  endfunction

  function automatic rsp_t forecast_span(input req_t r);
    rsp_t        o;
    int unsigned a;
    int unsigned b;
    int unsigned sd, sm, sy, ed, em, ey;
    o = '0;
    sd = 32'(r.start_day);
    sm = 32'(r.start_month);
    sy = 32'(r.start_year);
    ed = 32'(r.end_day);
    em = 32'(r.end_month);
    ey = 32'(r.end_year);
    if (date_is_real(sd, sm, sy) && date_is_real(ed, em, ey)) begin
      a = day_number(sd, sm, sy);
      b = day_number(ed, em, ey);
      o.both_valid = 1'b1;
      o.day_count = (b > a) ? DCNT_W'(b - a) : '0;
      o.start_weekday = weekday_of(sd, sm, sy);
      o.end_weekday = weekday_of(ed, em, ey);
    end
    return o;
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    $display("MISMATCH at response %0d, %s: got %0d, expected %0d",
             responses_seen, field, got, want);
    mismatches++;
  endtask

  task automatic add_row(input int unsigned sd, input int unsigned sm, input int unsigned sy,
                         input int unsigned ed, input int unsigned em, input int unsigned ey,
                         input bit typed, input rsp_t want);
    plan_row_t row;
    row.stim = {DAY_W'(sd), MON_W'(sm), YEAR_W'(sy), DAY_W'(ed), MON_W'(em), YEAR_W'(ey)};
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // Valid date with a year up to ymax; now and then a leap day, which fails in plain centuries.
  task automatic pick_date(input int unsigned ymax, output int unsigned d,
                           output int unsigned m, output int unsigned y);
    y = $urandom_range(1, ymax);
    m = $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) begin
      y = (y / 4) * 4;
      if (y == 0) y = 4;
      m = 2;
      d = 29;
    end else begin
      d = $urandom_range(1, month_length(m, is_leap_year(y)));
    end
  endtask

  // The sender offers requests in bursts with idle gaps between them.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_spans.push_back(typed ? want : forecast_span(r));
    requests_sent++;
  endtask

  // Response checker.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_spans.size() == 0) begin
        report("response with no request pending", 32'(rsp), 0);
      end else begin
        want = pending_spans.pop_front();
        if (rsp.both_valid !== want.both_valid) report("both_valid", 32'(rsp.both_valid),
                                                       32'(want.both_valid));
        if (rsp.day_count !== want.day_count) report("day_count", 32'(rsp.day_count),
                                                     32'(want.day_count));
        if (rsp.start_weekday !== want.start_weekday) report("start_weekday",
                                                             32'(rsp.start_weekday),
                                                             32'(want.start_weekday));
        if (rsp.end_weekday !== want.end_weekday) report("end_weekday",
                                                         32'(rsp.end_weekday),
                                                         32'(want.end_weekday));
        if (want.both_valid) begin
          dated_responses++;
          if (32'(want.day_count) > widest_span) widest_span = 32'(want.day_count);
        end
      end
      responses_seen++;
    end
  end

  // Consumer: ready follows a changing pattern, with one long hold-off on request.
  initial begin
    int       seg_left;
    rx_mode_t mode;
    bit       parked;
    seg_left = 0;
    mode = RX_OPEN;
    parked = 1'b0;
    forever begin
      @(posedge clk);
      if (park_receiver && !parked) begin
        parked = 1'b1;
        rsp_ready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          mode = rx_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          RX_OPEN:   rsp_ready <= 1'b1;
          RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_ready <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  // Ends the run when neither side has moved for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    req_t        r;
    int unsigned sd, sm, sy, ed, em, ey;
    int unsigned len;
    int          kind;
    bit          wide;
    bit          on_end;
    fault_t      fault;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the calendar, with results known by hand.
    add_row(1, 1, 1, 1, 1, 1, 1'b1, {1'b1, 22'd0, 3'd2, 3'd2});
    add_row(1, 1, 1, 31, 12, 9999, 1'b1, {1'b1, 22'd3652058, 3'd2, 3'd6});
    add_row(31, 12, 9999, 1, 1, 1, 1'b1, {1'b1, 22'd0, 3'd6, 3'd2});
    // Rejected dates of every kind.
    add_row(0, 1, 2000, 1, 1, 2000, 1'b1, REJECTED);
    add_row(1, 1, 2000, 31, 15, 16383, 1'b1, REJECTED);
    add_row(1, 0, 2000, 1, 1, 2000, 1'b1, REJECTED);
    add_row(1, 13, 2000, 1, 1, 2000, 1'b1, REJECTED);
    add_row(1, 1, 0, 1, 1, 1, 1'b1, REJECTED);
    add_row(1, 1, 1, 1, 1, 10000, 1'b1, REJECTED);
    add_row(29, 2, 1900, 1, 3, 1900, 1'b1, REJECTED);
    add_row(29, 2, 2023, 1, 3, 2023, 1'b1, REJECTED);
    add_row(31, 4, 2021, 1, 5, 2021, 1'b1, REJECTED);
    add_row(31, 1, 1, 0, 1, 1, 1'b1, REJECTED);
    // Leap rules, month and year boundaries, equal dates and a start after the end.
    add_row(29, 2, 2000, 1, 3, 2000, 1'b0, REJECTED);
    add_row(29, 2, 2024, 28, 2, 2025, 1'b0, REJECTED);
    add_row(28, 2, 1900, 1, 3, 1900, 1'b0, REJECTED);
    add_row(31, 1, 1, 1, 2, 1, 1'b0, REJECTED);
    add_row(15, 6, 2021, 15, 6, 2021, 1'b0, REJECTED);
    add_row(1, 3, 2021, 28, 2, 2021, 1'b0, REJECTED);
    add_row(30, 11, 5, 31, 12, 5, 1'b0, REJECTED);
    add_row(1, 1, 1, 31, 1, 1, 1'b0, REJECTED);
    add_row(1, 12, 1, 1, 1, 2, 1'b0, REJECTED);
    add_row(16, 8, 8191, 17, 8, 8192, 1'b0, REJECTED);

    foreach (plan[i]) begin
      pace();
      send_request(plan[i].stim, plan[i].typed, plan[i].want);
    end

    // Let the block drain completely before the random part.
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0) @(posedge clk);
    burst_left = 0;

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 3) begin
        // Short requests back to back while the consumer holds off, so the input stalls.
        park_receiver = 1'b1;
        for (int f = 0; f < FILL_REQS; f++) begin
          pick_date(20, sd, sm, sy);
          pick_date(20, ed, em, ey);
          r = {DAY_W'(sd), MON_W'(sm), YEAR_W'(sy), DAY_W'(ed), MON_W'(em), YEAR_W'(ey)};
          send_request(r, 1'b0, REJECTED);
        end
      end
      pace();
      kind = $urandom_range(0, 99);
      wide = ($urandom_range(0, 19) == 0);
      pick_date(wide ? YEAR_LIMIT : 400, sd, sm, sy);
      pick_date(wide ? YEAR_LIMIT : 400, ed, em, ey);
      if (kind < 6) begin
        ed = sd;
        em = sm;
        ey = sy;
      end else if (kind >= 70 && kind < 85) begin
        // One field of one date pushed out of range.
        on_end = 1'($urandom_range(0, 1));
        fault = fault_t'($urandom_range(0, 5));
        if (on_end) len = month_length(em, is_leap_year(ey));
        else len = month_length(sm, is_leap_year(sy));
        case (fault)
          BAD_DAY_ZERO:   if (on_end) ed = 0; else sd = 0;
          BAD_DAY_HIGH:   if (on_end) ed = (len < 31) ? $urandom_range(len + 1, 31) : 0;
                          else sd = (len < 31) ? $urandom_range(len + 1, 31) : 0;
          BAD_MONTH_ZERO: if (on_end) em = 0; else sm = 0;
          BAD_MONTH_HIGH: if (on_end) em = $urandom_range(13, 15);
                          else sm = $urandom_range(13, 15);
          BAD_YEAR_ZERO:  if (on_end) ey = 0; else sy = 0;
          default:        if (on_end) ey = $urandom_range(YEAR_LIMIT + 1, (1 << YEAR_W) - 1);
                          else sy = $urandom_range(YEAR_LIMIT + 1, (1 << YEAR_W) - 1);
        endcase
      end else if (kind >= 85) begin
        sd = $urandom_range(0, 31);
        sm = $urandom_range(0, 15);
        sy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << YEAR_W) - 1)
                                          : $urandom_range(0, 40);
        ed = $urandom_range(0, 31);
        em = $urandom_range(0, 15);
        ey = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << YEAR_W) - 1)
                                          : $urandom_range(0, 40);
      end
      r = {DAY_W'(sd), MON_W'(sm), YEAR_W'(sy), DAY_W'(ed), MON_W'(em), YEAR_W'(ey)};
      send_request(r, 1'b0, REJECTED);
    end

    req_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_spans.size() != 0) report("responses still missing", pending_spans.size(), 0);

    $display("Run covered %0d requests and %0d responses, %0d of them with two valid dates.",
             requests_sent, responses_seen, dated_responses);
    $display("Longest span checked: %0d days; mismatches: %0d.", widest_span, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
